// ===== rtl/pphd_pkg.sv =====
// Shared types, widths and arctangent constants for the point pair heading block.
`default_nettype none
package pphd_pkg;

  localparam int unsigned COORD_W  = 16;
  localparam int unsigned DIFF_W   = 17;
  localparam int unsigned PRESHIFT = 14;
  localparam int unsigned XY_W     = 34;
  localparam int unsigned Z_W      = 25;
  localparam int unsigned ATAN_W   = 23;
  localparam int unsigned PHI_W    = 16;
  localparam int unsigned HEAD_W   = 18;
  localparam int unsigned TABLE_LEN = 24;

  localparam logic [ATAN_W-1:0] DEG90_FINE = 23'd5898240;
  localparam logic [PHI_W-1:0]  DEG90_PHI  = 16'd23040;
  localparam logic signed [HEAD_W-1:0] DEG90  = 18'sd23040;
  localparam logic signed [HEAD_W-1:0] DEG180 = 18'sd46080;

  typedef struct packed {
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
  } cordic_t;

  typedef struct packed {
    logic dx_neg;
    logic dx_zero;
    logic dy_neg;
    logic dy_zero;
  } quad_t;

  // atan(2^-i) in 1/65536 degree
  function automatic logic [ATAN_W-1:0] pphd_atan(input int unsigned idx);
    logic [ATAN_W-1:0] v;
    case (idx)
      0:  v = 23'd2949120;
      1:  v = 23'd1740967;
      2:  v = 23'd919879;
      3:  v = 23'd466945;
      4:  v = 23'd234379;
      5:  v = 23'd117304;
      6:  v = 23'd58666;
      7:  v = 23'd29335;
      8:  v = 23'd14668;
      9:  v = 23'd7334;
      10: v = 23'd3667;
      11: v = 23'd1833;
      12: v = 23'd917;
      13: v = 23'd458;
      14: v = 23'd229;
      15: v = 23'd115;
      16: v = 23'd57;
      17: v = 23'd29;
      18: v = 23'd14;
      19: v = 23'd7;
      20: v = 23'd4;
      21: v = 23'd2;
      22: v = 23'd1;
      default: v = 23'd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/pphd_prep.sv =====
// Input stage: coordinate differences, magnitudes and quadrant flags.
`default_nettype none
module pphd_prep
  import pphd_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      en,
  input  wire logic                      in_valid,
  input  wire logic signed [COORD_W-1:0] first_x,
  input  wire logic signed [COORD_W-1:0] first_y,
  input  wire logic signed [COORD_W-1:0] second_x,
  input  wire logic signed [COORD_W-1:0] second_y,
  output logic                           valid_r,
  output cordic_t                        vec_r,
  output quad_t                          quad_r
);

  logic signed [DIFF_W-1:0] dx;
  logic signed [DIFF_W-1:0] dy;
  logic signed [DIFF_W-1:0] dx_abs;
  logic signed [DIFF_W-1:0] dy_abs;
  cordic_t                  vec_nxt;
  quad_t                    quad_nxt;

  always_comb begin
    dx     = DIFF_W'(second_x) - DIFF_W'(first_x);
    dy     = DIFF_W'(second_y) - DIFF_W'(first_y);
    dx_abs = dx[DIFF_W-1] ? -dx : dx;
    dy_abs = dy[DIFF_W-1] ? -dy : dy;
    vec_nxt.x = $signed({{(XY_W-COORD_W-PRESHIFT){1'b0}}, dy_abs[COORD_W-1:0],
                         {PRESHIFT{1'b0}}});
    vec_nxt.y = $signed({{(XY_W-COORD_W-PRESHIFT){1'b0}}, dx_abs[COORD_W-1:0],
                         {PRESHIFT{1'b0}}});
    vec_nxt.z = '0;
    quad_nxt.dx_neg  = dx[DIFF_W-1];
    quad_nxt.dx_zero = (dx == '0);
    quad_nxt.dy_neg  = dy[DIFF_W-1];
    quad_nxt.dy_zero = (dy == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vec_r  <= vec_nxt;
      quad_r <= quad_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/pphd_cell.sv =====
// One CORDIC vectoring micro-rotation with its pipeline register.
`default_nettype none
module pphd_cell
  import pphd_pkg::*;
#(
  parameter int unsigned SHIFT = 0
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    en,
  input  wire logic    in_valid,
  input  wire cordic_t vec_in,
  input  wire quad_t   quad_in,
  output logic         valid_r,
  output cordic_t      vec_r,
  output quad_t        quad_r
);

  localparam logic signed [Z_W-1:0] ATAN = $signed(Z_W'(pphd_atan(SHIFT)));

  logic signed [XY_W-1:0] xs;
  logic signed [XY_W-1:0] ys;
  cordic_t                vec_nxt;

  always_comb begin
    xs = vec_in.x >>> SHIFT;
    ys = vec_in.y >>> SHIFT;
    if (!vec_in.y[XY_W-1]) begin
      vec_nxt.x = vec_in.x + ys;
      vec_nxt.y = vec_in.y - xs;
      vec_nxt.z = vec_in.z + ATAN;
    end else begin
      vec_nxt.x = vec_in.x - ys;
      vec_nxt.y = vec_in.y + xs;
      vec_nxt.z = vec_in.z - ATAN;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vec_r  <= vec_nxt;
      quad_r <= quad_in;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/pphd_fold.sv =====
// Output stage: clamp and round the angle, fold by quadrant, hold the result beat.
`default_nettype none
module pphd_fold
  import pphd_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   en,
  input  wire logic                   in_valid,
  input  wire logic signed [Z_W-1:0]  z_in,
  input  wire quad_t                  quad_in,
  output logic                        valid_r,
  output logic signed [HEAD_W-1:0]    heading_r
);

  logic [ATAN_W-1:0]         z_clamp;
  logic [ATAN_W:0]           z_round;
  logic [PHI_W-1:0]          phi;
  logic signed [HEAD_W-1:0]  a;
  logic signed [HEAD_W-1:0]  heading_nxt;

  always_comb begin
    if (z_in[Z_W-1]) begin
      z_clamp = '0;
    end else if (z_in[Z_W-2:0] > (Z_W-1)'(DEG90_FINE)) begin
      z_clamp = DEG90_FINE;
    end else begin
      z_clamp = z_in[ATAN_W-1:0];
    end
    z_round = {1'b0, z_clamp} + (ATAN_W+1)'(128);
    if (quad_in.dx_zero) begin
      phi = '0;
    end else if (quad_in.dy_zero) begin
      phi = DEG90_PHI;
    end else begin
      phi = z_round[ATAN_W:8];
    end
    a = quad_in.dx_neg ? -$signed(HEAD_W'(phi)) : $signed(HEAD_W'(phi));
    if ((quad_in.dx_neg || quad_in.dx_zero) && (quad_in.dy_neg || quad_in.dy_zero)) begin
      heading_nxt = -DEG180 - a - DEG90;
    end else if (!quad_in.dx_neg && (quad_in.dy_neg || quad_in.dy_zero)) begin
      heading_nxt = DEG180 - a - DEG90;
    end else begin
      heading_nxt = a - DEG90;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      heading_r <= heading_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/point_pair_heading_angle.sv =====
// Top level: point pair heading angle over a pipelined CORDIC cell chain.
//
//  channel | direction | tdata fields (low bit up)                      | tuser/tlast
//  in_     | slave     | first_x[15:0] first_y[31:16] second_x[47:32]    | none
//          |           | second_y[63:48]                                 |
//  out_    | master    | heading[17:0], zero pad [23:18]                 | none
//
// One point pair per cycle sustained while the output is not stalled; stages in order
// are the input stage, one cell per CORDIC iteration and the output stage.
// Synchronous active-low reset clears the valid bits of every stage.
// A stalled output beat freezes the whole chain; in_tready follows it.
`default_nettype none
module point_pair_heading_angle
  import pphd_pkg::*;
#(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [63:0] in_tdata,   // first_x, first_y, second_x, second_y
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata   // heading, zero pad
);

  logic                      advance;
  logic                      stage_valid [0:CORDIC_STEPS];
  cordic_t                   stage_vec   [0:CORDIC_STEPS];
  quad_t                     stage_quad  [0:CORDIC_STEPS];
  logic signed [HEAD_W-1:0]  heading;

  assign advance   = !out_tvalid || out_tready;
  assign in_tready = advance;

  pphd_prep u_prep (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (advance),
    .in_valid (in_tvalid),
    .first_x  ($signed(in_tdata[15:0])),
    .first_y  ($signed(in_tdata[31:16])),
    .second_x ($signed(in_tdata[47:32])),
    .second_y ($signed(in_tdata[63:48])),
    .valid_r  (stage_valid[0]),
    .vec_r    (stage_vec[0]),
    .quad_r   (stage_quad[0])
  );

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
    pphd_cell #(
      .SHIFT (i)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (advance),
      .in_valid (stage_valid[i]),
      .vec_in   (stage_vec[i]),
      .quad_in  (stage_quad[i]),
      .valid_r  (stage_valid[i+1]),
      .vec_r    (stage_vec[i+1]),
      .quad_r   (stage_quad[i+1])
    );
  end

  pphd_fold u_fold (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (advance),
    .in_valid  (stage_valid[CORDIC_STEPS]),
    .z_in      (stage_vec[CORDIC_STEPS].z),
    .quad_in   (stage_quad[CORDIC_STEPS]),
    .valid_r   (out_tvalid),
    .heading_r (heading)
  );

  assign out_tdata = {6'b0, heading};

  a_heading_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (heading >= -18'sd69120) && (heading <= 18'sd23040))
    else $error("heading out of range");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && !stage_valid[0])
    else $error("valid bits not cleared by reset");

  a_rose_from_chain: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(stage_valid[CORDIC_STEPS]))
    else $error("output beat without a beat at the chain end");

  a_stall_freezes: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> $stable(stage_valid[CORDIC_STEPS]))
    else $error("chain moved during an output stall");

endmodule
`default_nettype wire
